@@ hdl/c2dr_pkg.sv @@
// Shared types, codes and constants for the single-channel convolution core.
// Used by every module under hdl but c2dr_ram; depends on nothing else.
package c2dr_pkg;

  // Default store sizes, handed to the top-level parameters.
  localparam int DEF_MAX_IMAGE_SIDE  = 64;
  localparam int DEF_MAX_KERNEL_SIDE = 7;

  // Limits applied to the configuration registers at use.
  localparam int KSIDE_CAP  = 7;
  localparam int STRIDE_MAX = 8;
  localparam int PAD_MAX    = 6;

  // Field and datapath widths.
  localparam int SAMPLE_W  = 16;
  localparam int ACT_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 9;   // effective image side, up to 127
  localparam int KIDX_W    = 3;   // kernel tap counters, side capped at 7
  localparam int COORD_W   = 12;  // signed image coordinate of a tap
  localparam int ACC_W     = 40;  // bias plus up to 49 products

  // Item actions.
  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_PIXEL  = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd5;

  // Effective configuration after range limiting.
  typedef struct packed {
    logic [2:0]         k;
    logic [3:0]         s;
    logic [2:0]         p;
    logic [DIM_W-1:0]   h;
    logic [DIM_W-1:0]   w;
    logic signed [31:0] bias;
  } cfg_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;   // load the bias into the accumulator
    logic vld;   // tap lies inside the image
    logic last;  // final tap of the window
  } mac_ctl_t;

endpackage

@@ hdl/c2dr_cfg.sv @@
// Configuration registers of the convolution core and their range limiting.
// Depends on c2dr_pkg.
module c2dr_cfg import c2dr_pkg::*; #(
  parameter int MaxImageSide  = DEF_MAX_IMAGE_SIDE,
  parameter int MaxKernelSide = DEF_MAX_KERNEL_SIDE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output cfg_t                 cfg_o
);

  localparam int KCap = (MaxKernelSide < KSIDE_CAP) ? MaxKernelSide : KSIDE_CAP;

  logic [2:0]         ksize_q;
  logic [3:0]         stride_q;
  logic [2:0]         pad_q;
  logic [6:0]         height_q;
  logic [6:0]         width_q;
  logic signed [31:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q  <= 3'd3;
      stride_q <= 4'd1;
      pad_q    <= 3'd0;
      height_q <= 7'd64;
      width_q  <= 7'd64;
      bias_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KSIZE:  ksize_q  <= cfg_data_i[2:0];
        REG_STRIDE: stride_q <= cfg_data_i[3:0];
        REG_PAD:    pad_q    <= cfg_data_i[2:0];
        REG_HEIGHT: height_q <= cfg_data_i[6:0];
        REG_WIDTH:  width_q  <= cfg_data_i[6:0];
        REG_BIAS:   bias_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ksize_q == 3'd0) begin
      cfg_o.k = 3'd1;
    end else if (int'(ksize_q) > KCap) begin
      cfg_o.k = 3'(KCap);
    end else begin
      cfg_o.k = ksize_q;
    end

    if (stride_q == 4'd0) begin
      cfg_o.s = 4'd1;
    end else if (int'(stride_q) > STRIDE_MAX) begin
      cfg_o.s = 4'(STRIDE_MAX);
    end else begin
      cfg_o.s = stride_q;
    end

    cfg_o.p = (int'(pad_q) > PAD_MAX) ? 3'(PAD_MAX) : pad_q;

    if (height_q == 7'd0) begin
      cfg_o.h = DIM_W'(1);
    end else if (int'(height_q) > MaxImageSide) begin
      cfg_o.h = DIM_W'(MaxImageSide);
    end else begin
      cfg_o.h = DIM_W'(height_q);
    end

    if (width_q == 7'd0) begin
      cfg_o.w = DIM_W'(1);
    end else if (int'(width_q) > MaxImageSide) begin
      cfg_o.w = DIM_W'(MaxImageSide);
    end else begin
      cfg_o.w = DIM_W'(width_q);
    end

    cfg_o.bias = bias_q;
  end

endmodule

@@ hdl/c2dr_ram.sv @@
// Single-port-write, single-port-read sample memory with registered read data.
// Holds kernel weights or image pixels; depends on nothing else.
module c2dr_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/c2dr_mac.sv @@
// Shared multiply-accumulate unit: one product per cycle into a wide accumulator,
// followed by ReLU and saturation of the final sum. Depends on c2dr_pkg.
module c2dr_mac import c2dr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctl_t                   ctl_i,
  input  logic signed [31:0]         bias_i,
  input  logic signed [SAMPLE_W-1:0] pix_i,
  input  logic signed [SAMPLE_W-1:0] wt_i,
  output logic                       done_o,
  output logic [ACT_W-1:0]           act_o
);

  logic signed [2*SAMPLE_W-1:0] prod_q;
  logic                         prod_vld_q;
  logic                         prod_last_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic                         done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      prod_vld_q  <= ctl_i.vld;
      prod_last_q <= ctl_i.last;
      done_q      <= prod_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pix_i * wt_i;
    if (ctl_i.clr) begin
      acc_q <= ACC_W'(bias_i);
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Negative sums clamp to zero; anything above the 31-bit range saturates.
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      act_o = '0;
    end else if (|acc_q[ACC_W-2:ACT_W]) begin
      act_o = '1;
    end else begin
      act_o = acc_q[ACT_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

@@ hdl/conv2d_relu_single_channel_core.sv @@
// Top level of the single-channel convolution core with ReLU: tap sequencer,
// stores and port logic. Depends on c2dr_pkg, c2dr_cfg, c2dr_ram and c2dr_mac.
//
// Usage:
// - Configuration channel (cfg_valid_i/cfg_ready_o, index and data) is always
//   ready; write it only while no query is in progress. Indexes above 5 are
//   ignored.
// - Input channel: each item either loads one kernel weight, loads one image
//   pixel or queries one output point. A load gives no result. Loads to
//   coordinates beyond the stores, and action 3, are dropped.
// - A query walks the K x K window through one shared multiplier, one tap per
//   cycle, then waits for the accumulator to finish; a query off the output
//   grid skips the walk and answers with status 1. The input is not ready
//   while a query runs, so a new item is taken only once the query is
//   through.
// - Output channel holds one result in a register. The core accepts further
//   items while that result waits; a second query completes only once the
//   receiver has taken the first, and stalls in its final state until then.
// - Reset restores the register defaults and clears all control state. The
//   stores are not cleared: every entry must be written before it is read.
module conv2d_relu_single_channel_core import c2dr_pkg::*; #(
  parameter int MaxImageSide  = DEF_MAX_IMAGE_SIDE,
  parameter int MaxKernelSide = DEF_MAX_KERNEL_SIDE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [5:0]                 row_i,
  input  logic [5:0]                 col_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       status_o,
  output logic [ACT_W-1:0]           activation_o
);

  localparam int ImgDepth = MaxImageSide * MaxImageSide;
  localparam int KerDepth = MaxKernelSide * MaxKernelSide;
  localparam int ImgAw    = (ImgDepth > 1) ? $clog2(ImgDepth) : 1;
  localparam int KerAw    = (KerDepth > 1) ? $clog2(KerDepth) : 1;
  localparam int ImgIw    = (MaxImageSide > 1) ? $clog2(MaxImageSide) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  cfg_t cfg;

  logic [2:0]                state_q, state_d;
  logic [5:0]                qrow_q, qcol_q;
  logic                      err_q;
  logic signed [COORD_W-1:0] base_r_q, base_c_q;
  logic [KIDX_W-1:0]         ki_q, kj_q;
  logic                      s1_vld_q, s1_last_q;

  logic                      in_acc;
  logic [9:0]                rs, cs;
  logic [9:0]                span_h, span_w;
  logic                      fit;
  logic [COORD_W-1:0]        ir, ic;
  logic                      tap_in;
  logic                      tap_last;
  logic [KIDX_W-1:0]         k_last;

  logic                      img_we, ker_we;
  logic [ImgAw-1:0]          img_waddr, img_raddr;
  logic [KerAw-1:0]          ker_waddr, ker_raddr;
  logic [SAMPLE_W-1:0]       pix_rd, wt_rd;

  mac_ctl_t                  mac_ctl;
  logic                      mac_done;
  logic [ACT_W-1:0]          mac_act;

  logic                      out_valid_q, status_q;
  logic [ACT_W-1:0]          act_q;

  c2dr_cfg #(
    .MaxImageSide  (MaxImageSide),
    .MaxKernelSide (MaxKernelSide)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Loads go straight into the stores in the cycle they are accepted.
  assign img_we = in_acc && (action_i == ACT_PIXEL) &&
                  (int'(row_i) < MaxImageSide) && (int'(col_i) < MaxImageSide);
  assign ker_we = in_acc && (action_i == ACT_WEIGHT) &&
                  (int'(row_i) < MaxKernelSide) && (int'(col_i) < MaxKernelSide);
  assign img_waddr = ImgAw'(row_i) * ImgAw'(MaxImageSide) + ImgAw'(col_i);
  assign ker_waddr = KerAw'(row_i) * KerAw'(MaxKernelSide) + KerAw'(col_i);

  // Grid check without a divider: a row is on the grid when its window,
  // starting at row * stride, still ends inside the padded image.
  assign rs     = 10'(qrow_q) * 10'(cfg.s);
  assign cs     = 10'(qcol_q) * 10'(cfg.s);
  assign span_h = 10'(cfg.h) + 10'({cfg.p, 1'b0});
  assign span_w = 10'(cfg.w) + 10'({cfg.p, 1'b0});
  assign fit    = ((rs + 10'(cfg.k)) <= span_h) && ((cs + 10'(cfg.k)) <= span_w);

  // Current tap in image coordinates; taps in the padding read as zero.
  assign ir     = base_r_q + COORD_W'(ki_q);
  assign ic     = base_c_q + COORD_W'(kj_q);
  assign tap_in = !ir[COORD_W-1] && !ic[COORD_W-1] &&
                  (ir < COORD_W'(cfg.h)) && (ic < COORD_W'(cfg.w));
  assign k_last   = cfg.k - 3'd1;
  assign tap_last = (ki_q == k_last) && (kj_q == k_last);

  assign img_raddr = ImgAw'(ir[ImgIw-1:0]) * ImgAw'(MaxImageSide) + ImgAw'(ic[ImgIw-1:0]);
  assign ker_raddr = KerAw'(ki_q) * KerAw'(MaxKernelSide) + KerAw'(kj_q);

  c2dr_ram #(
    .Depth (ImgDepth),
    .AddrW (ImgAw),
    .DataW (SAMPLE_W)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (sample_i),
    .raddr_i (img_raddr),
    .rdata_o (pix_rd)
  );

  c2dr_ram #(
    .Depth (KerDepth),
    .AddrW (KerAw),
    .DataW (SAMPLE_W)
  ) u_ker_ram (
    .clk_i   (clk_i),
    .we_i    (ker_we),
    .waddr_i (ker_waddr),
    .wdata_i (sample_i),
    .raddr_i (ker_raddr),
    .rdata_o (wt_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (action_i == ACT_QUERY)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = fit ? S_RUN : S_FIN;
      S_RUN: begin
        if (tap_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ki_q      <= '0;
      kj_q      <= '0;
      err_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_vld_q  <= (state_q == S_RUN) && tap_in;
      s1_last_q <= (state_q == S_RUN) && tap_last;
      if (state_q == S_CHECK) begin
        err_q <= !fit;
        ki_q  <= '0;
        kj_q  <= '0;
      end else if (state_q == S_RUN) begin
        if (kj_q == k_last) begin
          kj_q <= '0;
          ki_q <= ki_q + 3'd1;
        end else begin
          kj_q <= kj_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (action_i == ACT_QUERY)) begin
      qrow_q <= row_i;
      qcol_q <= col_i;
    end
    if (state_q == S_CHECK) begin
      base_r_q <= COORD_W'(rs) - COORD_W'(cfg.p);
      base_c_q <= COORD_W'(cs) - COORD_W'(cfg.p);
    end
  end

  assign mac_ctl.clr  = (state_q == S_CHECK);
  assign mac_ctl.vld  = s1_vld_q;
  assign mac_ctl.last = s1_last_q;

  c2dr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .bias_i (cfg.bias),
    .pix_i  (pix_rd),
    .wt_i   (wt_rd),
    .done_o (mac_done),
    .act_o  (mac_act)
  );

  // Result register: a finished query is loaded once the previous result is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
      status_q <= err_q;
      act_q    <= err_q ? '0 : mac_act;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign activation_o = act_q;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> activation_o == '0)
    else $error("off-grid result carries a non-zero activation");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == S_WAIT)
    else $error("accumulator finished outside the wait state");

  a_check_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> $past(in_valid_i && in_ready_o && action_i == ACT_QUERY))
    else $error("grid check entered without an accepted query item");

  a_fin_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> (state_q == S_FIN || state_q == S_IDLE))
    else $error("final state left for something other than idle");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for conv2d_relu_single_channel_core: weight, pixel and query
// items, directed then random, checked against an in-bench convolution predictor.
// Depends on c2dr_pkg and the core RTL; reads no files.
module tb_top;
  import c2dr_pkg::*;

  localparam int IMG_SIDE      = DEF_MAX_IMAGE_SIDE;
  localparam int KER_SIDE      = DEF_MAX_KERNEL_SIDE;
  localparam int ITEM_TARGET   = 550;
  localparam int PHASE_ITEMS   = 45;
  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_MAX    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [1:0]           ACT_SPARE    = 2'd3;

  localparam logic signed [31:0]         BIAS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]         BIAS_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = 16'sh8000;
  localparam longint                     ACT_TOP  = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]                 action;
    logic [5:0]                 row;
    logic [5:0]                 col;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [ACT_W-1:0] activation;
  } point_t;

  typedef struct {
    int k, s, p, h, w, oh, ow;
  } geom_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [31:0]                cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 action_i    = '0;
  logic [5:0]                 row_i       = '0;
  logic [5:0]                 col_i       = '0;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       status_o;
  logic [ACT_W-1:0]           activation_o;

  conv2d_relu_single_channel_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .activation_o (activation_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register copies, as written through the configuration channel.
  logic [2:0]         ksize_r  = 3'd3;
  logic [3:0]         stride_r = 4'd1;
  logic [2:0]         pad_r    = 3'd0;
  logic [6:0]         height_r = 7'd64;
  logic [6:0]         width_r  = 7'd64;
  logic signed [31:0] bias_r   = '0;

  logic signed [SAMPLE_W-1:0] pixel_mem  [IMG_SIDE*IMG_SIDE];
  logic signed [SAMPLE_W-1:0] weight_mem [KER_SIDE*KER_SIDE];
  // Entries already written by queued items; used to keep queries off unwritten entries.
  bit pixel_loaded  [IMG_SIDE*IMG_SIDE];
  bit weight_loaded [KER_SIDE*KER_SIDE];

  item_t  pending_items[$];
  point_t expected_points[$];

  bit       in_taken = 1'b0;
  bit       gentle   = 1'b0;
  int       burst_left = 0;
  int       gap_left   = 0;
  item_t    next_item;
  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  logic [7:0] rx_pattern = 8'hFF;
  point_t   got, want;
  int       idle_cycles = 0;
  int       mismatches  = 0;
  int       n_items = 0, n_settings = 0, n_results = 0;
  int       n_off = 0, n_sat = 0, n_zero = 0;
  int       phase_idx = 0;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int axis_len(int side, int pad, int k, int s);
    if (side + 2 * pad < k) return 0;
    return (side + 2 * pad - k) / s + 1;
  endfunction

  // Register values as the core uses them, range-limited, and the output grid.
  function automatic geom_t geometry();
    geom_t g;
    g.k  = clip(int'(ksize_r), 1, (KSIDE_CAP < KER_SIDE) ? KSIDE_CAP : KER_SIDE);
    g.s  = clip(int'(stride_r), 1, STRIDE_MAX);
    g.p  = clip(int'(pad_r), 0, PAD_MAX);
    g.h  = clip(int'(height_r), 1, IMG_SIDE);
    g.w  = clip(int'(width_r), 1, IMG_SIDE);
    g.oh = axis_len(g.h, g.p, g.k, g.s);
    g.ow = axis_len(g.w, g.p, g.k, g.s);
    return g;
  endfunction

  function automatic point_t conv_point(int r, int c);
    geom_t  g;
    point_t pt;
    longint acc;
    int     ir, ic;
    g  = geometry();
    pt = '0;
    if (r >= g.oh || c >= g.ow) begin
      pt.status = 1'b1;
      return pt;
    end
    acc = longint'(bias_r);
    for (int ki = 0; ki < g.k; ki++) begin
      ir = r * g.s + ki - g.p;
      if (ir >= 0 && ir < g.h) begin
        for (int kj = 0; kj < g.k; kj++) begin
          ic = c * g.s + kj - g.p;
          if (ic >= 0 && ic < g.w)
            acc += longint'(pixel_mem[ir*IMG_SIDE+ic]) *
                   longint'(weight_mem[ki*KER_SIDE+kj]);
        end
      end
    end
    if (acc < 0) acc = 0;
    if (acc > ACT_TOP) acc = ACT_TOP;
    pt.activation = acc[ACT_W-1:0];
    return pt;
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_KSIZE:  ksize_r  = val[2:0];
      REG_STRIDE: stride_r = val[3:0];
      REG_PAD:    pad_r    = val[2:0];
      REG_HEIGHT: height_r = val[6:0];
      REG_WIDTH:  width_r  = val[6:0];
      REG_BIAS:   bias_r   = val;
      default: ;
    endcase
  endfunction

  function automatic void absorb_item(item_t it);
    case (it.action)
      ACT_WEIGHT: begin
        if (it.row < KER_SIDE && it.col < KER_SIDE)
          weight_mem[it.row*KER_SIDE+it.col] = it.sample;
      end
      ACT_PIXEL:  pixel_mem[it.row*IMG_SIDE+it.col] = it.sample;
      ACT_QUERY:  expected_points = {expected_points,
                                     conv_point(int'(it.row), int'(it.col))};
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t: %s", $time, what);
  endfunction

  // Acceptance of items and register writes, and the result check.
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) store_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        absorb_item({action_i, row_i, col_i, sample_i});
      end
      if (out_valid_o && out_ready_i) begin
        got = {status_o, activation_o};
        if (expected_points.size() == 0) begin
          flag_mismatch($sformatf("result with none expected: status %0b activation %08h",
                                  got.status, got.activation));
        end else begin
          want = expected_points.pop_front();
          n_results++;
          if (want.status) n_off++;
          else if (&want.activation) n_sat++;
          else if (want.activation == '0) n_zero++;
          if (got.status != want.status || got.activation != want.activation)
            flag_mismatch($sformatf(
              "expected status %0b activation %08h, got status %0b activation %08h",
              want.status, want.activation, got.status, got.activation));
        end
      end
    end
  end

  // Sender: bursts of items separated by random gaps, now and then a long burst.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        {action_i, row_i, col_i, sample_i} <= next_item;
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60)
                                                   : $urandom_range(0, 4);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switches between open, mostly ready, sparse and a rotating pattern.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 3));
      rx_left    = $urandom_range(20, 120);
      rx_pattern = 8'($urandom);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        out_ready_i <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: %0d cycles without a handshake", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    if (gentle) return SAMPLE_W'($urandom_range(0, 1023) - 512);
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'($urandom_range(0, 1023) - 512);
      1: return ($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_bias();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return BIAS_MAX;
      2: return BIAS_MIN;
      3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_side();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
      1, 2: return $urandom_range(13, 64);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Grid coordinate, mostly near the origin so that pixels are reused.
  function automatic int pick_coord(int n);
    int m;
    m = (n > 64) ? 64 : n;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, m - 1);
      1: return m - 1 - $urandom_range(0, ((m < 3) ? m : 3) - 1);
      default: return $urandom_range(0, ((m < 5) ? m : 5) - 1);
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] a, int r, int c,
                                     logic signed [SAMPLE_W-1:0] smp);
    item_t it;
    it.action = a;
    it.row    = 6'(r);
    it.col    = 6'(c);
    it.sample = smp;
    pending_items = {pending_items, it};
    n_items++;
    if (a == ACT_PIXEL) begin
      pixel_loaded[it.row*IMG_SIDE+it.col] = 1'b1;
    end else if (a == ACT_WEIGHT && r < KER_SIDE && c < KER_SIDE) begin
      weight_loaded[r*KER_SIDE+c] = 1'b1;
    end
  endfunction

  // A query, preceded by writes of any weight or in-image pixel its window lacks.
  function automatic void queue_query(int r, int c);
    geom_t g;
    int    ir, ic;
    g = geometry();
    if (r < g.oh && c < g.ow) begin
      for (int ki = 0; ki < g.k; ki++) begin
        for (int kj = 0; kj < g.k; kj++) begin
          if (!weight_loaded[ki*KER_SIDE+kj]) queue_item(ACT_WEIGHT, ki, kj, rand_sample());
          ir = r * g.s + ki - g.p;
          ic = c * g.s + kj - g.p;
          if (ir >= 0 && ir < g.h && ic >= 0 && ic < g.w && !pixel_loaded[ir*IMG_SIDE+ic])
            queue_item(ACT_PIXEL, ir, ic, rand_sample());
        end
      end
    end
    queue_item(ACT_QUERY, r, c, rand_sample());
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_regs(int k, int s, int p, int h, int w, logic [31:0] b, bit spare);
    set_reg(REG_KSIZE, k);
    set_reg(REG_STRIDE, s);
    set_reg(REG_PAD, p);
    set_reg(REG_HEIGHT, h);
    set_reg(REG_WIDTH, w);
    set_reg(REG_BIAS, b);
    if (spare) begin
      set_reg(REG_SPARE_LO, $urandom);
      set_reg(REG_SPARE_HI, $urandom);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  // Waits until every queued item is taken and every result is back, then lets
  // a query's worth of cycles pass so that the core is idle.
  task automatic drain();
    @(posedge clk_i);
    while (pending_items.size() != 0 || (in_valid_i && !in_ready_o)) @(posedge clk_i);
    @(negedge clk_i);
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(int idx);
    int    k, s, p, h, w, roll, quota_end;
    geom_t g;
    case (idx)
      0: begin k = 7; s = 1;  p = 6; h = 64;  w = 64; end
      1: begin k = 1; s = 8;  p = 0; h = 1;   w = 64; end
      2: begin k = 0; s = 15; p = 7; h = 127; w = 0;  end
      default: begin
        k = $urandom_range(0, 7);
        s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
        p = $urandom_range(0, 7);
        h = pick_side();
        w = pick_side();
      end
    endcase
    load_regs(k, s, p, h, w, rand_bias(), $urandom_range(0, 3) == 0);
    gentle    = ($urandom_range(0, 1) != 0);
    g         = geometry();
    quota_end = n_items + PHASE_ITEMS;
    while (n_items < quota_end) begin
      roll = $urandom_range(0, 99);
      if (roll < 55 && g.oh > 0 && g.ow > 0) begin
        queue_query(pick_coord(g.oh), pick_coord(g.ow));
      end else if (roll < 65) begin
        queue_query($urandom_range(0, 63), $urandom_range(0, 63));
      end else if (roll < 80) begin
        if ($urandom_range(0, 1) != 0)
          queue_item(ACT_PIXEL, $urandom_range(0, g.h - 1), $urandom_range(0, g.w - 1),
                     rand_sample());
        else
          queue_item(ACT_PIXEL, $urandom_range(0, 63), $urandom_range(0, 63), rand_sample());
      end else if (roll < 90) begin
        queue_item(ACT_WEIGHT, $urandom_range(0, KER_SIDE - 1),
                   $urandom_range(0, KER_SIDE - 1), rand_sample());
      end else if (roll < 95) begin
        queue_item(ACT_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                   SAMPLE_W'($urandom));
      end else if ($urandom_range(0, 1) != 0) begin
        queue_item(ACT_WEIGHT, $urandom_range(KER_SIDE, 63), $urandom_range(0, 63),
                   rand_sample());
      end else begin
        queue_item(ACT_WEIGHT, $urandom_range(0, 63), $urandom_range(KER_SIDE, 63),
                   rand_sample());
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: off-grid queries, action 3 and weight writes beyond the store.
    queue_query(62, 0);
    queue_query(0, 62);
    queue_query(63, 63);
    queue_item(ACT_SPARE, 63, 63, SMP_MIN);
    queue_item(ACT_WEIGHT, KER_SIDE, 0, SMP_MIN);
    queue_item(ACT_WEIGHT, 0, 63, SMP_MAX);
    drain();

    // One-pixel image, one-tap kernel: largest product, then a negative sum clamped.
    load_regs(1, 1, 0, 1, 1, '0, 1'b0);
    queue_item(ACT_WEIGHT, 0, 0, SMP_MIN);
    queue_item(ACT_PIXEL, 0, 0, SMP_MIN);
    queue_query(0, 0);
    queue_query(1, 0);
    queue_query(0, 1);
    queue_item(ACT_PIXEL, 0, 0, SMP_MAX);
    queue_query(0, 0);
    drain();

    // Largest bias on top of a positive product saturates.
    load_regs(1, 1, 0, 1, 1, BIAS_MAX, 1'b0);
    queue_item(ACT_WEIGHT, 0, 0, SMP_MAX);
    queue_query(0, 0);
    drain();

    // Kernel larger than the padded image: the grid is empty.
    load_regs(7, 1, 0, 1, 1, BIAS_MIN, 1'b0);
    queue_query(0, 0);
    drain();

    // Out-of-range register values and writes to unused indexes.
    load_regs(0, 0, 7, 0, 0, 32'h0001_0000, 1'b1);
    queue_query(6, 6);
    queue_query(0, 0);
    queue_query(12, 12);
    queue_query(13, 0);
    drain();

    while (n_items < ITEM_TARGET) begin
      random_phase(phase_idx);
      phase_idx++;
    end

    $display("Covered %0d items under %0d register settings, %0d results checked:",
             n_items, n_settings, n_results);
    $display("%0d off the grid, %0d saturated, %0d clamped or zero.", n_off, n_sat, n_zero);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
